@@ sv/psch_pkg.sv @@
`default_nettype none

package psch_pkg;

    typedef enum logic [1:0] {
        K_TICK  = 2'd0,
        K_SUB   = 2'd1,
        K_UNSUB = 2'd2,
        K_RESP  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RK_STATUS = 2'd0,
        RK_REQ    = 2'd1,
        RK_NOTIFY = 2'd2
    } rkind_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EV,
        S_END,
        S_MVRD,
        S_MVWR
    } state_t;

    typedef struct packed {
        logic [15:0] reg_id;
        logic [15:0] period;
        logic [16:0] elapsed;
        logic [31:0] value;
    } entry_t;

    typedef struct packed {
        logic    load;
        logic    rd_walk;
        logic    rd_slot;
        logic    rd_last;
        logic    inc_idx;
        logic    tick_wr;
        logic    flush;
        logic    sub_sts;
        status_t sub_code;
        logic    append;
        logic    move_wr;
        logic    notify;
    } cmd_t;

    typedef struct packed {
        kind_t op_kind;
        logic  walk_done;
        logic  match;
        logic  due;
        logic  changed;
        logic  slot_valid;
        logic  full;
        logic  pend_vld;
    } sts_t;

endpackage

`default_nettype wire

@@ sv/psch_ctrl.sv @@
`default_nettype none

module psch_ctrl import psch_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire sts_t sts,
    output cmd_t      cmd,
    output logic      busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.sub_code = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (sts.op_kind == K_RESP)
                begin
                    if (sts.slot_valid)
                    begin
                        cmd.rd_slot = 1'b1;
                        state_next  = S_EV;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (sts.walk_done)
                begin
                    state_next = S_END;
                end
                else
                begin
                    cmd.rd_walk = 1'b1;
                    state_next  = S_EV;
                end
            end
            S_EV:
            begin
                case (sts.op_kind)
                    K_TICK:
                    begin
                        cmd.tick_wr = 1'b1;
                        cmd.inc_idx = 1'b1;
                        state_next  = S_RD;
                    end
                    K_SUB:
                    begin
                        if (sts.match)
                        begin
                            cmd.sub_sts  = 1'b1;
                            cmd.sub_code = ST_DUP;
                            state_next   = S_IDLE;
                        end
                        else
                        begin
                            cmd.inc_idx = 1'b1;
                            state_next  = S_RD;
                        end
                    end
                    K_UNSUB:
                    begin
                        if (sts.match)
                        begin
                            state_next = S_MVRD;
                        end
                        else
                        begin
                            cmd.inc_idx = 1'b1;
                            state_next  = S_RD;
                        end
                    end
                    default:
                    begin
                        cmd.notify = sts.changed;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_END:
            begin
                case (sts.op_kind)
                    K_TICK:
                    begin
                        cmd.flush = sts.pend_vld;
                    end
                    K_SUB:
                    begin
                        cmd.sub_sts = 1'b1;
                        if (sts.full)
                        begin
                            cmd.sub_code = ST_FULL;
                        end
                        else
                        begin
                            cmd.append = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                state_next = S_IDLE;
            end
            S_MVRD:
            begin
                cmd.rd_last = 1'b1;
                state_next  = S_MVWR;
            end
            S_MVWR:
            begin
                cmd.move_wr = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

`ifndef SYNTHESIS
    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE)
        else $error("load outside idle");
    a_move_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MVWR |-> $past(state_reg) == S_MVRD)
        else $error("move write without read of last entry");
    a_idle_after_move: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MVWR |=> state_reg == S_IDLE)
        else $error("move write not final");
`endif

endmodule

`default_nettype wire

@@ sv/psch_dp.sv @@
`default_nettype none

module psch_dp import psch_pkg::*;
#(
    parameter int CAP = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic [1:0]  kind,
    input  wire logic [15:0] reg_id,
    input  wire logic [15:0] poll_period,
    input  wire logic [3:0]  slot,
    input  wire logic        read_ok,
    input  wire logic [31:0] read_value,
    input  wire cmd_t        cmd,
    output sts_t             sts,
    output logic             result_valid,
    output logic [1:0]       result_kind,
    output logic [15:0]      out_reg_id,
    output logic [3:0]       out_slot,
    output logic [31:0]      out_value,
    output logic [1:0]       status,
    output logic             last
);

    localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int CNT_W = $clog2(CAP + 1);

    logic [15:0]      base_reg;
    kind_t            op_kind_reg;
    logic [15:0]      op_reg_id_reg;
    logic [15:0]      op_period_reg;
    logic [3:0]       op_slot_reg;
    logic             op_ok_reg;
    logic [31:0]      op_value_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             pend_vld_reg;
    logic [15:0]      pend_reg_id_reg;
    logic [3:0]       pend_slot_reg;
    entry_t           rd_q_reg;

    logic             res_vld_reg;
    rkind_t           res_kind_reg;
    logic [15:0]      res_reg_id_reg;
    logic [3:0]       res_slot_reg;
    logic [31:0]      res_value_reg;
    status_t          res_status_reg;
    logic             res_last_reg;

    entry_t           mem [CAP];

    logic [16:0]      sum;
    logic [CNT_W-1:0] last_idx;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             emit_req;
    logic             emit;

    assign sum      = rd_q_reg.elapsed + 17'(base_reg);
    assign last_idx = cnt_reg - CNT_W'(1);

    assign sts.op_kind    = op_kind_reg;
    assign sts.walk_done  = (idx_reg >= cnt_reg);
    assign sts.match      = (rd_q_reg.reg_id == op_reg_id_reg);
    assign sts.due        = (sum >= 17'(rd_q_reg.period));
    assign sts.changed    = op_ok_reg && (rd_q_reg.value != op_value_reg);
    assign sts.slot_valid = (5'(op_slot_reg) < 5'(cnt_reg));
    assign sts.full       = (cnt_reg == CNT_W'(CAP));
    assign sts.pend_vld   = pend_vld_reg;

    assign rd_en = cmd.rd_walk | cmd.rd_slot | cmd.rd_last;

    always_comb
    begin
        if (cmd.rd_slot)
        begin
            rd_addr = op_slot_reg[IDX_W-1:0];
        end
        else if (cmd.rd_last)
        begin
            rd_addr = last_idx[IDX_W-1:0];
        end
        else
        begin
            rd_addr = idx_reg[IDX_W-1:0];
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg[IDX_W-1:0];
        wr_data = rd_q_reg;
        if (cmd.tick_wr)
        begin
            wr_en           = 1'b1;
            wr_data.elapsed = sts.due ? 17'd0 : sum;
        end
        else if (cmd.append)
        begin
            wr_en           = 1'b1;
            wr_addr         = cnt_reg[IDX_W-1:0];
            wr_data.reg_id  = op_reg_id_reg;
            wr_data.period  = op_period_reg;
            wr_data.elapsed = '0;
            wr_data.value   = '0;
        end
        else if (cmd.move_wr)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.notify)
        begin
            wr_en         = 1'b1;
            wr_addr       = op_slot_reg[IDX_W-1:0];
            wr_data.value = op_value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.append)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (cmd.move_wr)
        begin
            cnt_next = last_idx;
        end
    end

    assign emit_req = cmd.tick_wr & sts.due & pend_vld_reg;
    assign emit     = emit_req | cmd.flush | cmd.sub_sts | cmd.notify;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= 16'd1;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            pend_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
            cnt_reg     <= cnt_next;
            res_vld_reg <= emit;
            if (cmd.load)
            begin
                idx_reg      <= '0;
                pend_vld_reg <= 1'b0;
            end
            else
            begin
                if (cmd.inc_idx)
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                if (cmd.tick_wr && sts.due)
                begin
                    pend_vld_reg <= 1'b1;
                end
                else if (cmd.flush)
                begin
                    pend_vld_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_kind_reg   <= kind_t'(kind);
            op_reg_id_reg <= reg_id;
            op_period_reg <= poll_period;
            op_slot_reg   <= slot;
            op_ok_reg     <= read_ok;
            op_value_reg  <= read_value;
        end
        if (cmd.tick_wr && sts.due)
        begin
            pend_reg_id_reg <= rd_q_reg.reg_id;
            pend_slot_reg   <= 4'(idx_reg);
        end
        if (emit_req || cmd.flush)
        begin
            res_kind_reg   <= RK_REQ;
            res_reg_id_reg <= pend_reg_id_reg;
            res_slot_reg   <= pend_slot_reg;
            res_value_reg  <= '0;
            res_status_reg <= ST_OK;
            res_last_reg   <= cmd.flush;
        end
        else if (cmd.sub_sts)
        begin
            res_kind_reg   <= RK_STATUS;
            res_reg_id_reg <= op_reg_id_reg;
            res_slot_reg   <= cmd.append ? 4'(cnt_reg) : 4'd0;
            res_value_reg  <= '0;
            res_status_reg <= cmd.sub_code;
            res_last_reg   <= 1'b1;
        end
        else if (cmd.notify)
        begin
            res_kind_reg   <= RK_NOTIFY;
            res_reg_id_reg <= rd_q_reg.reg_id;
            res_slot_reg   <= op_slot_reg;
            res_value_reg  <= op_value_reg;
            res_status_reg <= ST_OK;
            res_last_reg   <= 1'b1;
        end
    end

    assign result_valid = res_vld_reg;
    assign result_kind  = res_kind_reg;
    assign out_reg_id   = res_reg_id_reg;
    assign out_slot     = res_slot_reg;
    assign out_value    = res_value_reg;
    assign status       = res_status_reg;
    assign last         = res_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAP))
        else $error("entry count beyond capacity");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(cnt_reg) |-> (cnt_reg == $past(cnt_reg) + CNT_W'(1))
                           || (cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("entry count jumped");
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && res_kind_reg != RK_REQ |-> res_last_reg)
        else $error("single result not marked last");
`endif

endmodule

`default_nettype wire

@@ sv/periodic_register_poll_scheduler_top.sv @@
// Periodic register poll scheduler.
// Command port: an item is taken when start is high and busy is low; kind
// selects tick, subscribe, unsubscribe or read response. busy stays high
// until the item is finished.
// Results leave one per transfer on result_valid, each for a single cycle,
// with last marking the final result of an item. The receiver cannot stall.
// The base step is written through cfg_we/cfg_wdata; the user must do so only
// while the block is idle, which the block itself does not enforce.
// Per item (one memory port); the next item is taken once busy is low:
//   tick          requests emitted as the walk proceeds
//   subscribe     one status result
//   unsubscribe   no result
//   read response at most one notify, none for a slot beyond the table
// Results are registered: each appears in the cycle after the one producing it.
// Reset empties the table (count to zero) and sets the base step to 1; table
// contents are not cleared, so no clearing pass is needed.
`default_nettype none

module periodic_register_poll_scheduler_top import psch_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  kind,
    input  wire logic [15:0] reg_id,
    input  wire logic [15:0] poll_period,
    input  wire logic [3:0]  slot,
    input  wire logic        read_ok,
    input  wire logic [31:0] read_value,
    output logic             result_valid,
    output logic [1:0]       result_kind,
    output logic [15:0]      out_reg_id,
    output logic [3:0]       out_slot,
    output logic [31:0]      out_value,
    output logic [1:0]       status,
    output logic             last
);

    localparam int CAP = (SLOTS < 16) ? SLOTS : 16;

    cmd_t cmd;
    sts_t sts;

    psch_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    psch_dp #(
        .CAP (CAP)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .kind         (kind),
        .reg_id       (reg_id),
        .poll_period  (poll_period),
        .slot         (slot),
        .read_ok      (read_ok),
        .read_value   (read_value),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .out_reg_id   (out_reg_id),
        .out_slot     (out_slot),
        .out_value    (out_value),
        .status       (status),
        .last         (last)
    );

endmodule

`default_nettype wire
